[hw/rtl/bpa_pkg.sv]
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared constants, types and codes of the bracket pair arc parser.
// ----------------------------------------------------------------------------
package bpa_pkg;

    // Longest structure in bases, and the depth of the open-bracket stack
    localparam int MaxLength = 4096;
    localparam int AddrW     = $clog2(MaxLength);
    localparam int CountW    = AddrW + 1;

    // Fixed widths of the result fields
    localparam int PosOutW   = 12;
    localparam int CntOutW   = 13;

    // Structure characters
    localparam logic [7:0] SymDot   = 8'h2E;
    localparam logic [7:0] SymFree  = 8'h5F;
    localparam logic [7:0] SymOpen  = 8'h28;
    localparam logic [7:0] SymClose = 8'h29;
    localparam logic [7:0] SymSpace = 8'h20;

    typedef enum logic [2:0] {
        ClsRestricted = 3'd0,
        ClsFree       = 3'd1,
        ClsOpen       = 3'd2,
        ClsClose      = 3'd3,
        ClsUnknown    = 3'd4
    } t_class;

    typedef struct packed {
        logic [PosOutW-1:0] position;
        t_class             base_class;
        logic [PosOutW-1:0] partner;
        logic               covered;
        logic [PosOutW-1:0] enclosing;
        logic               underflow;
        logic               overflow;
        logic               unclosed;
        logic [CntOutW-1:0] unclosed_count;
        logic               end_of_structure;
    } t_result;

endpackage

[hw/rtl/bpa_stack_ram.sv]
// ----------------------------------------------------------------------------
// bpa_stack_ram
// Open-bracket position stack: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bpa_stack_ram (
    input  logic                      i_clk,
    input  logic                      i_wr_en,
    input  logic [bpa_pkg::AddrW-1:0] i_wr_addr,
    input  logic [bpa_pkg::AddrW-1:0] i_wr_data,
    input  logic [bpa_pkg::AddrW-1:0] i_rd_addr,
    output logic [bpa_pkg::AddrW-1:0] o_rd_data
);

    logic [bpa_pkg::AddrW-1:0] r_mem [bpa_pkg::MaxLength];
    logic [bpa_pkg::AddrW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[hw/rtl/bpa_core.sv]
// ----------------------------------------------------------------------------
// bpa_core
// Classifies each symbol, keeps position, sticky flags and the bracket stack.
// The top entry is held in a register; the entry below it is prefetched from
// the stack memory every cycle, addressed from the next stack count.
// ----------------------------------------------------------------------------
module bpa_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_symbol,
    input  logic             i_last,
    output logic             o_res_valid,
    output bpa_pkg::t_result o_result
);

    localparam int AW = bpa_pkg::AddrW;
    localparam int CW = bpa_pkg::CountW;

    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_next_pos, n_next_pos;
    logic          r_underflow, n_underflow;
    logic          r_overflow, n_overflow;
    logic [AW-1:0] r_top, n_top;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] second;
    logic [CW-1:0] rd_count;

    logic             is_space;
    logic             beyond;
    logic             has_top;
    logic             full;
    logic [AW-1:0]    pos;
    bpa_pkg::t_class  cls;
    logic [AW-1:0]    partner;
    logic             covered;
    logic [AW-1:0]    enclosing;

    bpa_stack_ram u_stack (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (pos),
        .i_rd_addr (rd_addr),
        .o_rd_data (second)
    );

    always_comb begin
        unique case (i_symbol)
            bpa_pkg::SymDot:   cls = bpa_pkg::ClsRestricted;
            bpa_pkg::SymFree:  cls = bpa_pkg::ClsFree;
            bpa_pkg::SymOpen:  cls = bpa_pkg::ClsOpen;
            bpa_pkg::SymClose: cls = bpa_pkg::ClsClose;
            default:           cls = bpa_pkg::ClsUnknown;
        endcase
    end

    assign is_space = (i_symbol == bpa_pkg::SymSpace);
    assign beyond   = (r_next_pos >= CW'(bpa_pkg::MaxLength));
    assign has_top  = (r_count != '0);
    assign full     = (r_count == CW'(bpa_pkg::MaxLength));
    assign pos      = beyond ? AW'(bpa_pkg::MaxLength - 1) : r_next_pos[AW-1:0];
    assign wr_addr  = r_count[AW-1:0];

    always_comb begin
        n_count     = r_count;
        n_next_pos  = r_next_pos;
        n_underflow = r_underflow;
        n_overflow  = r_overflow;
        n_top       = r_top;
        wr_en       = 1'b0;
        partner     = '0;
        covered     = 1'b0;
        enclosing   = '0;
        o_res_valid = 1'b0;
        o_result    = '0;

        if (i_accept && !is_space) begin
            o_res_valid = 1'b1;
            if (beyond) begin
                n_overflow = 1'b1;
            end else begin
                n_next_pos = r_next_pos + CW'(1);
            end

            if (!beyond && cls == bpa_pkg::ClsOpen) begin
                // enclosing arc is the top before this push
                covered   = has_top;
                enclosing = has_top ? r_top : '0;
                if (full) begin
                    n_overflow = 1'b1;
                end else begin
                    wr_en   = 1'b1;
                    n_count = r_count + CW'(1);
                    n_top   = pos;
                end
            end else begin
                if (!beyond && cls == bpa_pkg::ClsClose) begin
                    if (!has_top) begin
                        n_underflow = 1'b1;
                    end else begin
                        partner = r_top;
                        n_count = r_count - CW'(1);
                        n_top   = second;
                    end
                end
                covered   = (n_count != '0);
                enclosing = covered ? n_top : '0;
            end

            o_result.position         = bpa_pkg::PosOutW'(pos);
            o_result.base_class       = cls;
            o_result.partner          = bpa_pkg::PosOutW'(partner);
            o_result.covered          = covered;
            o_result.enclosing        = bpa_pkg::PosOutW'(enclosing);
            o_result.underflow        = n_underflow;
            o_result.overflow         = n_overflow;
            o_result.unclosed         = i_last && (n_count != '0);
            o_result.unclosed_count   = i_last ? bpa_pkg::CntOutW'(n_count) : '0;
            o_result.end_of_structure = i_last;
        end

        if (i_accept && i_last) begin
            n_count     = '0;
            n_next_pos  = '0;
            n_underflow = 1'b0;
            n_overflow  = 1'b0;
        end
    end

    // prefetch the entry just below the next top
    assign rd_count = n_count - CW'(2);
    assign rd_addr  = rd_count[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_next_pos  <= '0;
            r_underflow <= 1'b0;
            r_overflow  <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_next_pos  <= n_next_pos;
            r_underflow <= n_underflow;
            r_overflow  <= n_overflow;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top <= n_top;
    end

endmodule

[hw/rtl/bpa_out_buf.sv]
// ----------------------------------------------------------------------------
// bpa_out_buf
// Two-entry result buffer; full flag is registered and stalls the input side.
// ----------------------------------------------------------------------------
module bpa_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  bpa_pkg::t_result i_data,
    input  logic             i_stall,
    output logic             o_valid,
    output bpa_pkg::t_result o_data,
    output logic             o_full
);

    bpa_pkg::t_result r_buf [2];
    logic             r_wr_ptr, n_wr_ptr;
    logic             r_rd_ptr, n_rd_ptr;
    logic [1:0]       r_cnt, n_cnt;
    logic             pop;

    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_data  = r_buf[r_rd_ptr];
    assign pop     = o_valid && !i_stall;

    always_comb begin
        n_wr_ptr = r_wr_ptr ^ i_push;
        n_rd_ptr = r_rd_ptr ^ pop;
        n_cnt    = r_cnt + 2'(i_push) - 2'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_data;
        end
    end

endmodule

[hw/rtl/bracket_pair_arc_parser.sv]
// ----------------------------------------------------------------------------
// bracket_pair_arc_parser
// Dot-bracket structure parser: one character in, at most one base result out.
//
// Input channel: i_in_valid / o_in_stall with i_symbol and i_last. An item is
// taken at a clock edge with i_in_valid high and o_in_stall low.
// Output channel: o_out_valid / i_out_stall with one port per result field.
// A space gives no result; every other character gives exactly one.
// A result enters the output buffer when its item is taken.
// Throughput: one item per cycle while o_in_stall is low. The top of stack
// is a register and the entry below it is prefetched from the stack memory
// each cycle, so pops and pushes may follow each other back to back.
// A two-entry result buffer sits on the output; o_in_stall rises only when
// both entries hold results the receiver has not yet taken. A stalled result
// holds its value.
// Reset clears position, stack depth, error flags and the result buffer; the
// stack memory itself needs no clearing. The item marked last ends the
// structure and clears position, stack depth and error flags after its result.
// ----------------------------------------------------------------------------
module bracket_pair_arc_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_symbol,
    input  logic        i_last,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [11:0] o_position,
    output logic [2:0]  o_base_class,
    output logic [11:0] o_partner,
    output logic        o_covered,
    output logic [11:0] o_enclosing,
    output logic        o_underflow,
    output logic        o_overflow,
    output logic        o_unclosed,
    output logic [12:0] o_unclosed_count,
    output logic        o_end_of_structure
);

    logic             accept;
    logic             res_valid;
    bpa_pkg::t_result res;
    bpa_pkg::t_result out_res;
    logic             buf_full;

    assign accept     = i_in_valid && !buf_full;
    assign o_in_stall = buf_full;

    bpa_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_symbol    (i_symbol),
        .i_last      (i_last),
        .o_res_valid (res_valid),
        .o_result    (res)
    );

    bpa_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_data  (out_res),
        .o_full  (buf_full)
    );

    assign o_position         = out_res.position;
    assign o_base_class       = out_res.base_class;
    assign o_partner          = out_res.partner;
    assign o_covered          = out_res.covered;
    assign o_enclosing        = out_res.enclosing;
    assign o_underflow        = out_res.underflow;
    assign o_overflow         = out_res.overflow;
    assign o_unclosed         = out_res.unclosed;
    assign o_unclosed_count   = out_res.unclosed_count;
    assign o_end_of_structure = out_res.end_of_structure;

endmodule

[sim/bracket_arc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bracket_arc_checker
// Watches both channels of the arc parser. Every taken character is run
// through a local model of the open-bracket stack. Each base result the block
// hands out is compared, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module bracket_arc_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_symbol,
    input  logic        i_last,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [11:0] i_position,
    input  logic [2:0]  i_base_class,
    input  logic [11:0] i_partner,
    input  logic        i_covered,
    input  logic [11:0] i_enclosing,
    input  logic        i_underflow,
    input  logic        i_overflow,
    input  logic        i_unclosed,
    input  logic [12:0] i_unclosed_count,
    input  logic        i_end_of_structure,
    output int          o_fail_count,
    output int          o_pending
);

    logic [bpa_pkg::PosOutW-1:0] open_positions [bpa_pkg::MaxLength];
    int                          open_depth;
    int                          next_base;
    logic                        underflow_seen;
    logic                        overflow_seen;
    bpa_pkg::t_result            expected_bases [$];
    int                          results_seen;

    function automatic void clear_structure();
        open_depth     = 0;
        next_base      = 0;
        underflow_seen = 1'b0;
        overflow_seen  = 1'b0;
    endfunction

    task automatic report_mismatch(input string msg);
        o_fail_count++;
        $display("[%0t] MISMATCH result %0d: %s", $realtime, results_seen, msg);
    endtask

    task automatic check_field(input string field, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d expected %0d", field, got, want));
    endtask

    // Stack walk for one character; spaces only matter when they end a structure
    task automatic predict_base(input logic [7:0] sym, input logic is_last);
        bpa_pkg::t_result r;
        int               pos;
        logic             beyond;
        logic             cover_done;
        if (sym == bpa_pkg::SymSpace) begin
            if (is_last)
                clear_structure();
            return;
        end
        r = '0;
        case (sym)
            bpa_pkg::SymDot:   r.base_class = bpa_pkg::ClsRestricted;
            bpa_pkg::SymFree:  r.base_class = bpa_pkg::ClsFree;
            bpa_pkg::SymOpen:  r.base_class = bpa_pkg::ClsOpen;
            bpa_pkg::SymClose: r.base_class = bpa_pkg::ClsClose;
            default:           r.base_class = bpa_pkg::ClsUnknown;
        endcase
        beyond = (next_base >= bpa_pkg::MaxLength);
        if (beyond) begin
            overflow_seen = 1'b1;
            pos = bpa_pkg::MaxLength - 1;
        end else begin
            pos = next_base;
            next_base++;
        end
        cover_done = 1'b0;
        if (!beyond && r.base_class == bpa_pkg::ClsOpen) begin
            // an open bracket is enclosed by the top before its own push
            if (open_depth > 0) begin
                r.covered   = 1'b1;
                r.enclosing = open_positions[open_depth-1];
            end
            cover_done = 1'b1;
            if (open_depth >= bpa_pkg::MaxLength) begin
                overflow_seen = 1'b1;
            end else begin
                open_positions[open_depth] = bpa_pkg::PosOutW'(pos);
                open_depth++;
            end
        end else if (!beyond && r.base_class == bpa_pkg::ClsClose) begin
            if (open_depth == 0) begin
                underflow_seen = 1'b1;
            end else begin
                open_depth--;
                r.partner = open_positions[open_depth];
            end
        end
        if (!cover_done && open_depth > 0) begin
            r.covered   = 1'b1;
            r.enclosing = open_positions[open_depth-1];
        end
        r.position         = bpa_pkg::PosOutW'(pos);
        r.underflow        = underflow_seen;
        r.overflow         = overflow_seen;
        r.unclosed         = is_last && open_depth != 0;
        r.unclosed_count   = is_last ? bpa_pkg::CntOutW'(open_depth) : '0;
        r.end_of_structure = is_last;
        expected_bases.push_back(r);
        if (is_last)
            clear_structure();
    endtask

    task automatic compare_result(input bpa_pkg::t_result want);
        check_field("position", 16'(i_position), 16'(want.position));
        check_field("base_class", 16'(i_base_class), 16'(want.base_class));
        check_field("partner", 16'(i_partner), 16'(want.partner));
        check_field("covered", 16'(i_covered), 16'(want.covered));
        check_field("enclosing", 16'(i_enclosing), 16'(want.enclosing));
        check_field("underflow", 16'(i_underflow), 16'(want.underflow));
        check_field("overflow", 16'(i_overflow), 16'(want.overflow));
        check_field("unclosed", 16'(i_unclosed), 16'(want.unclosed));
        check_field("unclosed_count", 16'(i_unclosed_count), 16'(want.unclosed_count));
        check_field("end_of_structure", 16'(i_end_of_structure),
                    16'(want.end_of_structure));
    endtask

    // Results are checked before the same edge's item is predicted: a result
    // can never belong to the item taken at the same edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_bases.delete();
            clear_structure();
        end else begin
            if (i_out_valid === 1'b1 && i_out_stall === 1'b0) begin
                if (expected_bases.size() == 0)
                    report_mismatch($sformatf("unexpected result at position %0d",
                                              i_position));
                else
                    compare_result(expected_bases.pop_front());
                results_seen++;
            end
            if (i_in_valid === 1'b1 && i_in_stall === 1'b0)
                predict_base(i_symbol, i_last);
        end
        o_pending = expected_bases.size();
    end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives dot-bracket structures into the arc parser: a directed set of short
// structures, then random well-formed, broken and noisy structures with idle
// bursts on both channels. The checker beside the block predicts and compares
// every result.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CycleLimit  = 1_000_000;
    localparam int RandomItems = 2000;
    localparam int DrainCycles = 8;

    localparam int KindWell     = 0;
    localparam int KindBroken   = 1;
    localparam int KindNoise    = 2;
    localparam int KindSpaceEnd = 3;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic [7:0]  i_symbol    = 8'h00;
    logic        i_last      = 1'b0;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [11:0] o_position;
    logic [2:0]  o_base_class;
    logic [11:0] o_partner;
    logic        o_covered;
    logic [11:0] o_enclosing;
    logic        o_underflow;
    logic        o_overflow;
    logic        o_unclosed;
    logic [12:0] o_unclosed_count;
    logic        o_end_of_structure;

    int   fail_count;
    int   pending;
    int   bases_sent   = 0;
    int   cycle_count  = 0;
    logic idle_enabled = 1'b1;

    bracket_pair_arc_parser DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_symbol           (i_symbol),
        .i_last             (i_last),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_position         (o_position),
        .o_base_class       (o_base_class),
        .o_partner          (o_partner),
        .o_covered          (o_covered),
        .o_enclosing        (o_enclosing),
        .o_underflow        (o_underflow),
        .o_overflow         (o_overflow),
        .o_unclosed         (o_unclosed),
        .o_unclosed_count   (o_unclosed_count),
        .o_end_of_structure (o_end_of_structure)
    );

    bracket_arc_checker u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .i_in_stall         (o_in_stall),
        .i_symbol           (i_symbol),
        .i_last             (i_last),
        .i_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .i_position         (o_position),
        .i_base_class       (o_base_class),
        .i_partner          (o_partner),
        .i_covered          (o_covered),
        .i_enclosing        (o_enclosing),
        .i_underflow        (o_underflow),
        .i_overflow         (o_overflow),
        .i_unclosed         (o_unclosed),
        .i_unclosed_count   (o_unclosed_count),
        .i_end_of_structure (o_end_of_structure),
        .o_fail_count       (fail_count),
        .o_pending          (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < CycleLimit) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    // Receiver side: random stall bursts while idling is on
    initial begin
        forever begin
            @(posedge i_clk);
            if (idle_enabled && $urandom_range(0, 9) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic send_item(input logic [7:0] sym, input logic is_last);
        if (idle_enabled && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_symbol   <= sym;
        i_last     <= is_last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (sym != bpa_pkg::SymSpace)
            bases_sent++;
    endtask

    task automatic send_text(input string text);
        int n;
        for (n = 0; n < text.len(); n++)
            send_item(text[n], n == text.len() - 1);
    endtask

    task automatic send_structure(input int kind);
        logic [7:0] chars [$];
        logic [7:0] sym;
        int         len;
        int         depth_now;
        int         pick;
        int         closes;
        int         n;
        logic       balanced;
        balanced  = (kind == KindWell || kind == KindSpaceEnd);
        len       = $urandom_range(1, 40);
        depth_now = 0;
        for (n = 0; n < len; n++) begin
            pick = $urandom_range(0, 99);
            if (kind == KindNoise && pick < 50)
                sym = 8'($urandom_range(0, 255));
            else if (pick < 30)
                sym = bpa_pkg::SymOpen;
            else if (pick < 55)
                sym = (depth_now > 0 || !balanced) ? bpa_pkg::SymClose : bpa_pkg::SymDot;
            else if (pick < 70)
                sym = bpa_pkg::SymDot;
            else if (pick < 88)
                sym = bpa_pkg::SymFree;
            else
                sym = bpa_pkg::SymSpace;
            if (sym == bpa_pkg::SymOpen)
                depth_now++;
            else if (sym == bpa_pkg::SymClose && depth_now > 0)
                depth_now--;
            chars.push_back(sym);
        end
        closes = balanced ? depth_now : $urandom_range(0, depth_now);
        repeat (closes) chars.push_back(bpa_pkg::SymClose);
        if (kind == KindSpaceEnd)
            chars.push_back(bpa_pkg::SymSpace);
        for (n = 0; n < chars.size(); n++)
            send_item(chars[n], n == chars.size() - 1);
    endtask

    initial begin
        int pick;
        int kind;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: nesting, underflow, unknown characters, space ending an
        // open structure, unclosed brackets, clean state after each end
        send_text("((._))");
        send_text(")).");
        send_item(bpa_pkg::SymOpen, 1'b0);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(bpa_pkg::SymSpace, 1'b0);
        send_item(bpa_pkg::SymSpace, 1'b1);
        send_text("(()(");
        send_text("_");

        bases_sent = 0;
        while (bases_sent < RandomItems) begin
            if (bases_sent < RandomItems * 9 / 10)
                idle_enabled = ($urandom_range(0, 3) != 0);
            else
                idle_enabled = 1'b0;
            pick = $urandom_range(0, 9);
            if (pick < 6)
                kind = KindWell;
            else if (pick < 8)
                kind = KindBroken;
            else if (pick < 9)
                kind = KindNoise;
            else
                kind = KindSpaceEnd;
            send_structure(kind);
        end
        i_in_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
